// File: src/lrsr_pkg.sv
package lrsr_pkg;

    localparam int MAX_STATES     = 16;
    localparam int MAX_SYMBOLS    = 16;
    localparam int MAX_RULES      = 16;
    localparam int STACK_DEPTH    = 16;
    localparam int MAX_REDUCTIONS = 31;

    localparam int STATE_W = 4;
    localparam int SYM_W   = 4;
    localparam int RULE_W  = 4;
    localparam int SP_W    = 5;
    localparam int CNT_W   = 5;
    localparam int ADDR_W  = STATE_W + SYM_W;

    localparam logic [SP_W-1:0]  SP_FULL   = SP_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] RED_LIMIT = CNT_W'(MAX_REDUCTIONS);

    typedef enum logic [1:0] {
        OP_WR_ACTION = 2'd0,
        OP_WR_RULE   = 2'd1,
        OP_START     = 2'd2,
        OP_TOKEN     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_ERROR  = 2'd0,
        ACT_SHIFT  = 2'd1,
        ACT_REDUCE = 2'd2,
        ACT_ACCEPT = 2'd3
    } act_kind_t;

    typedef enum logic [2:0] {
        EV_REDUCE   = 3'd0,
        EV_SHIFT    = 3'd1,
        EV_ACCEPT   = 3'd2,
        EV_SYNTAX   = 3'd3,
        EV_UNKNOWN  = 3'd4,
        EV_OVERFLOW = 3'd5,
        EV_LIMIT    = 3'd6,
        EV_ACK      = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_FAILED   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOOK,
        B_ACT,
        B_SRD,
        B_GRD,
        B_GWAIT,
        B_GOTO
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic [STATE_W-1:0] state_sel;
        logic [SYM_W-1:0] symbol;
        act_kind_t        action_kind;
        logic [3:0]       action_target;
        logic [RULE_W-1:0] rule_sel;
        logic [SYM_W-1:0] rule_lhs;
        logic [3:0]       rule_length;
    } item_t;

    typedef struct packed {
        event_t            event_res;
        logic [RULE_W-1:0] rule_used;
        logic [STATE_W-1:0] top_state;
        logic [SP_W-1:0]   stack_depth;
        logic              last;
    } result_t;

endpackage

// File: src/lrsr_front.sv
module lrsr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 item_valid,
    output lrsr_pkg::item_t      item,
    input  logic                 item_pop
);

    lrsr_pkg::item_t q_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    lrsr_pkg::item_t in_item;
    logic            push;

    // classify the incoming transfer
    always_comb
    begin
        in_item.op            = lrsr_pkg::op_t'(s_tuser);
        in_item.state_sel     = s_tdata[3:0];
        in_item.symbol        = s_tdata[7:4];
        in_item.action_kind   = lrsr_pkg::act_kind_t'(s_tdata[9:8]);
        in_item.action_target = s_tdata[13:10];
        in_item.rule_sel      = s_tdata[17:14];
        in_item.rule_lhs      = s_tdata[21:18];
        in_item.rule_length   = s_tdata[25:22];
    end

    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(item_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: src/lrsr_back.sv
module lrsr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  lrsr_pkg::item_t      item,
    output logic                 item_pop,
    input  logic [4:0]           symbol_count,
    input  logic [4:0]           rule_count,
    output logic                 res_valid,
    output lrsr_pkg::result_t    res,
    input  logic                 res_ready
);

    localparam int AW = lrsr_pkg::ADDR_W;
    localparam int SW = lrsr_pkg::SP_W;

    // action table: memory plus reset-cleared valid bits
    logic [5:0]  act_mem [lrsr_pkg::MAX_STATES*lrsr_pkg::MAX_SYMBOLS];
    logic        act_vld_reg [lrsr_pkg::MAX_STATES*lrsr_pkg::MAX_SYMBOLS];
    logic [5:0]  act_q_reg;
    logic        act_vq_reg;
    logic        act_we;
    logic [AW-1:0] act_waddr;
    logic [5:0]  act_wdata;

    logic [7:0]  rule_mem [lrsr_pkg::MAX_RULES];
    logic        rule_we;

    logic [3:0]  stk_mem [lrsr_pkg::STACK_DEPTH+1];
    logic [3:0]  stk_q_reg;
    logic        stk_we;
    logic [SW-1:0] stk_waddr;
    logic [3:0]  stk_wdata;

    lrsr_pkg::back_state_t state_reg, state_next;
    lrsr_pkg::status_t     status_reg, status_next;
    logic [SW-1:0] sp_reg, sp_next;
    logic [3:0]    top_reg, top_next;
    logic [4:0]    red_reg, red_next;
    logic [3:0]    sym_reg, sym_next;
    logic [3:0]    rt_reg, rt_next;
    logic [3:0]    rl_reg, rl_next;
    logic [SW-1:0] nsp_reg, nsp_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [SW-1:0] saddr_reg, saddr_next;

    logic                 out_valid_reg;
    lrsr_pkg::result_t    out_reg;
    logic                 can_emit;
    logic                 emit;
    lrsr_pkg::event_t     emit_ev;
    logic [3:0]           emit_rule;
    logic                 emit_last;

    lrsr_pkg::act_kind_t  kind;
    logic [3:0]           tgt;
    logic [3:0]           rlhs, rlen;
    logic [3:0]           base;

    assign can_emit  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign kind = act_vq_reg ? lrsr_pkg::act_kind_t'(act_q_reg[5:4]) : lrsr_pkg::ACT_ERROR;
    assign tgt  = act_q_reg[3:0];
    assign rlhs = rule_mem[tgt][7:4];
    assign rlen = rule_mem[tgt][3:0];
    // base entry of the stack is always state 0
    assign base = (nsp_reg == '0) ? 4'd0 : stk_q_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrsr_pkg::B_IDLE:
            begin
                if (item_valid && can_emit && item.op == lrsr_pkg::OP_TOKEN
                    && status_reg == lrsr_pkg::ST_RUNNING
                    && {1'b0, item.symbol} < symbol_count)
                begin
                    state_next = lrsr_pkg::B_LOOK;
                end
            end
            lrsr_pkg::B_LOOK:  state_next = lrsr_pkg::B_ACT;
            lrsr_pkg::B_ACT:
            begin
                if (can_emit)
                begin
                    if (kind == lrsr_pkg::ACT_REDUCE && {1'b0, tgt} < rule_count
                        && red_reg != lrsr_pkg::RED_LIMIT
                        && SW'(rlen) <= sp_reg && {1'b0, rlhs} < symbol_count)
                    begin
                        state_next = lrsr_pkg::B_SRD;
                    end
                    else
                    begin
                        state_next = lrsr_pkg::B_IDLE;
                    end
                end
            end
            lrsr_pkg::B_SRD:   state_next = lrsr_pkg::B_GRD;
            lrsr_pkg::B_GRD:   state_next = lrsr_pkg::B_GWAIT;
            lrsr_pkg::B_GWAIT: state_next = lrsr_pkg::B_GOTO;
            lrsr_pkg::B_GOTO:
            begin
                if (can_emit)
                begin
                    if (kind == lrsr_pkg::ACT_SHIFT && nsp_reg != lrsr_pkg::SP_FULL)
                    begin
                        state_next = lrsr_pkg::B_LOOK;
                    end
                    else
                    begin
                        state_next = lrsr_pkg::B_IDLE;
                    end
                end
            end
            default:           state_next = lrsr_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        status_next = status_reg;
        sp_next     = sp_reg;
        top_next    = top_reg;
        red_next    = red_reg;
        sym_next    = sym_reg;
        rt_next     = rt_reg;
        rl_next     = rl_reg;
        nsp_next    = nsp_reg;
        addr_next   = addr_reg;
        saddr_next  = saddr_reg;
        item_pop    = 1'b0;
        act_we      = 1'b0;
        act_waddr   = {item.state_sel, item.symbol};
        act_wdata   = {item.action_kind, item.action_target};
        rule_we     = 1'b0;
        stk_we      = 1'b0;
        stk_waddr   = sp_reg + SW'(1);
        stk_wdata   = tgt;
        emit        = 1'b0;
        emit_ev     = lrsr_pkg::EV_ACK;
        emit_rule   = 4'd0;
        emit_last   = 1'b1;
        unique case (state_reg)
            lrsr_pkg::B_IDLE:
            begin
                if (item_valid && can_emit)
                begin
                    item_pop = 1'b1;
                    emit     = 1'b1;
                    unique case (item.op)
                        lrsr_pkg::OP_WR_ACTION: act_we = 1'b1;
                        lrsr_pkg::OP_WR_RULE:   rule_we = 1'b1;
                        lrsr_pkg::OP_START:
                        begin
                            sp_next     = '0;
                            top_next    = 4'd0;
                            status_next = lrsr_pkg::ST_RUNNING;
                        end
                        default:
                        begin
                            if (status_reg != lrsr_pkg::ST_RUNNING)
                            begin
                                emit_ev = lrsr_pkg::EV_SYNTAX;
                            end
                            else if ({1'b0, item.symbol} >= symbol_count)
                            begin
                                emit_ev     = lrsr_pkg::EV_UNKNOWN;
                                status_next = lrsr_pkg::ST_FAILED;
                            end
                            else
                            begin
                                emit      = 1'b0;
                                sym_next  = item.symbol;
                                red_next  = '0;
                                addr_next = {top_reg, item.symbol};
                            end
                        end
                    endcase
                end
            end
            lrsr_pkg::B_ACT:
            begin
                if (can_emit)
                begin
                    emit        = 1'b1;
                    status_next = lrsr_pkg::ST_FAILED;
                    unique case (kind)
                        lrsr_pkg::ACT_SHIFT:
                        begin
                            if (sp_reg == lrsr_pkg::SP_FULL)
                            begin
                                emit_ev = lrsr_pkg::EV_OVERFLOW;
                            end
                            else
                            begin
                                emit_ev     = lrsr_pkg::EV_SHIFT;
                                status_next = status_reg;
                                stk_we      = 1'b1;
                                sp_next     = sp_reg + SW'(1);
                                top_next    = tgt;
                            end
                        end
                        lrsr_pkg::ACT_ACCEPT:
                        begin
                            emit_ev     = lrsr_pkg::EV_ACCEPT;
                            status_next = lrsr_pkg::ST_ACCEPTED;
                        end
                        lrsr_pkg::ACT_REDUCE:
                        begin
                            if ({1'b0, tgt} >= rule_count)
                            begin
                                emit_ev = lrsr_pkg::EV_SYNTAX;
                            end
                            else if (red_reg == lrsr_pkg::RED_LIMIT)
                            begin
                                emit_ev = lrsr_pkg::EV_LIMIT;
                            end
                            else if (SW'(rlen) > sp_reg)
                            begin
                                emit_ev = lrsr_pkg::EV_LIMIT;
                            end
                            else if ({1'b0, rlhs} >= symbol_count)
                            begin
                                emit_ev = lrsr_pkg::EV_UNKNOWN;
                            end
                            else
                            begin
                                // start the goto lookup; nothing to report yet
                                emit        = 1'b0;
                                status_next = status_reg;
                                rt_next     = tgt;
                                rl_next     = rlhs;
                                nsp_next    = sp_reg - SW'(rlen);
                                saddr_next  = sp_reg - SW'(rlen);
                            end
                        end
                        default: emit_ev = lrsr_pkg::EV_SYNTAX;
                    endcase
                end
            end
            lrsr_pkg::B_GRD:
            begin
                addr_next = {base, rl_reg};
            end
            lrsr_pkg::B_GOTO:
            begin
                if (can_emit)
                begin
                    emit        = 1'b1;
                    status_next = lrsr_pkg::ST_FAILED;
                    if (kind != lrsr_pkg::ACT_SHIFT)
                    begin
                        emit_ev = lrsr_pkg::EV_SYNTAX;
                    end
                    else if (nsp_reg == lrsr_pkg::SP_FULL)
                    begin
                        emit_ev = lrsr_pkg::EV_OVERFLOW;
                    end
                    else
                    begin
                        emit_ev     = lrsr_pkg::EV_REDUCE;
                        emit_rule   = rt_reg;
                        emit_last   = 1'b0;
                        status_next = status_reg;
                        stk_we      = 1'b1;
                        stk_waddr   = nsp_reg + SW'(1);
                        sp_next     = nsp_reg + SW'(1);
                        top_next    = tgt;
                        red_next    = red_reg + 5'd1;
                        addr_next   = {tgt, sym_reg};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (act_we)
        begin
            act_mem[act_waddr] <= act_wdata;
        end
        act_q_reg <= act_mem[addr_reg];
        act_vq_reg <= act_vld_reg[addr_reg];
        if (rule_we)
        begin
            rule_mem[item.rule_sel] <= {item.rule_lhs, item.rule_length};
        end
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_q_reg <= stk_mem[saddr_reg];
        if (emit)
        begin
            out_reg.event_res   <= emit_ev;
            out_reg.rule_used   <= emit_rule;
            out_reg.top_state   <= top_next;
            out_reg.stack_depth <= sp_next;
            out_reg.last        <= emit_last;
        end
        sym_reg   <= sym_next;
        rt_reg    <= rt_next;
        rl_reg    <= rl_next;
        nsp_reg   <= nsp_next;
        saddr_reg <= saddr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lrsr_pkg::MAX_STATES*lrsr_pkg::MAX_SYMBOLS; i++)
            begin
                act_vld_reg[i] <= 1'b0;
            end
            state_reg     <= lrsr_pkg::B_IDLE;
            status_reg    <= lrsr_pkg::ST_RUNNING;
            sp_reg        <= '0;
            top_reg       <= 4'd0;
            red_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (act_we)
            begin
                act_vld_reg[act_waddr] <= 1'b1;
            end
            state_reg  <= state_next;
            status_reg <= status_next;
            sp_reg     <= sp_next;
            top_reg    <= top_next;
            red_reg    <= red_next;
            addr_reg   <= addr_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: src/lr_shift_reduce_parser_core.sv
// Channel | Dir | Signals                    | Content
// s_*     | in  | tvalid tready tdata tuser   | load, start and token items
// m_*     | out | tvalid tready tdata tuser   | parser events, tlast on final
// apb     | in  | psel penable pwrite paddr  | symbol_count @0, rule_count @4
//
// A load or start item is handled directly in the idle state; a token passes
// through the registered action-table read, and each reduction adds the
// stack read and the action-table read that feed the goto lookup.
// Reset clears the action-table valid bits at once; no clearing pass.
// A two-entry queue decouples input from the engine; the output register
// holds a result until it is taken, and the engine waits while it is held.
module lr_shift_reduce_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // state_sel[3:0] symbol[7:4] action_kind[9:8] action_target[13:10]
    // rule_sel[17:14] rule_lhs[21:18] rule_length[25:22]
    input  logic [31:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // rule_used[3:0] top_state[7:4] stack_depth[12:8]
    output logic [15:0] m_tdata,
    // event_res[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ADDR_SYMBOL_COUNT = 3'd0;
    localparam logic [2:0] ADDR_RULE_COUNT   = 3'd4;

    logic [4:0]          symbol_count_reg;
    logic [4:0]          rule_count_reg;
    logic                cfg_wr;
    logic                item_valid;
    logic                item_pop;
    lrsr_pkg::item_t     item;
    lrsr_pkg::result_t   res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr)
            ADDR_SYMBOL_COUNT: prdata = {27'd0, symbol_count_reg};
            ADDR_RULE_COUNT:   prdata = {27'd0, rule_count_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= 5'd9;
            rule_count_reg   <= 5'd6;
        end
        else if (cfg_wr)
        begin
            if (paddr == ADDR_SYMBOL_COUNT)
            begin
                symbol_count_reg <= pwdata[4:0];
            end
            else if (paddr == ADDR_RULE_COUNT)
            begin
                rule_count_reg <= pwdata[4:0];
            end
        end
    end

    lrsr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    lrsr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop),
        .symbol_count (symbol_count_reg),
        .rule_count   (rule_count_reg),
        .res_valid    (m_tvalid),
        .res          (res),
        .res_ready    (m_tready)
    );

    assign m_tdata = {3'd0, res.stack_depth, res.top_state, res.rule_used};
    assign m_tuser = res.event_res;
    assign m_tlast = res.last;

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.stack_depth <= lrsr_pkg::SP_FULL)
        else $error("stack depth beyond capacity");

    a_reduce_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.event_res == lrsr_pkg::EV_REDUCE |-> !res.last)
        else $error("reduce result marked last");

    a_rule_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.event_res != lrsr_pkg::EV_REDUCE |-> res.rule_used == 4'd0)
        else $error("rule index on a non-reduce result");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> item_valid)
        else $error("queue popped while empty");

endmodule
